>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the decaying sine generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DSG_ASSERT_IMP(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DSG_ASSERT_NXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/core/dsg_pkg.sv
// Constants, types and the quarter-wave sine table builder for the decaying sine generator.
package dsg_pkg;

   // Phase and table geometry
   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);

   // Field widths
   localparam int SINE_W  = 15;
   localparam int AMP_W   = 16;
   localparam int ENV_W   = 32;
   localparam int CFG_W   = 32;
   localparam int WORD_W  = 32;

   // Product of table value, amplitude (Q1.15) and envelope (Q1.31)
   localparam int PROD_W       = SINE_W + AMP_W + ENV_W;
   localparam int SAMPLE_SHIFT = SINE_W + ENV_W - 1;
   localparam int INT_W        = PROD_W - SAMPLE_SHIFT;

   // Bit-serial multiplier
   localparam int MUL_W     = 32;
   localparam int MUL_CNT_W = $clog2(MUL_W);

   // Float conversion: 24 mantissa bits plus one rounding bit
   localparam int MANT_BITS        = 25;
   localparam int MANT_CNT_W       = $clog2(MANT_BITS + 1);
   localparam int POS_W            = 8;
   localparam int FLOAT_EXP_W      = 8;
   localparam int FLOAT_FRAC_W     = 23;
   localparam int FLOAT_BIAS       = 127;
   localparam int FLOAT_EXP_OFFSET = FLOAT_BIAS - SAMPLE_SHIFT;

   localparam logic [SINE_W-1:0] FULL_SCALE  = SINE_W'(32767);
   localparam logic [ENV_W-1:0]  ONE_Q31     = 32'h8000_0000;
   localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

   // Register reset values
   localparam logic [CFG_W-1:0] PHASE_INC_RESET = '0;
   localparam logic [AMP_W-1:0] AMP_RESET       = 16'h8000;
   localparam logic [CFG_W-1:0] DECAY_RESET     = 32'hFFFF_FFFF;
   localparam logic [CFG_W-1:0] COUNT_RESET     = 32'd48000;

   // Output format codes
   localparam logic FMT_INT16   = 1'b0;
   localparam logic FMT_FLOAT32 = 1'b1;

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_INC = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DECAY     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COUNT     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FORMAT    = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ROM,
      S_MUL1,
      S_MUL2,
      S_CONV,
      S_PACK,
      S_MUL3,
      S_OUT
   } dsg_state_type;

   typedef logic [SINE_TABLE_DEPTH-1:0][SINE_W-1:0] sine_rom_type;

   // One table entry from a Q30 Taylor series of sin(x) up to x^17
   function automatic logic [SINE_W-1:0] sine_entry(input logic [SINE_IDX_BITS-1:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum_u;
      logic [63:0] v;
      longint      sum;
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 272;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
         sum = longint'(1) << 30;
      end
      sum_u = 64'(sum);
      v     = (sum_u * 64'(FULL_SCALE) + 64'h2000_0000) >> 30;
      if (v > 64'(FULL_SCALE)) begin
         v = 64'(FULL_SCALE);
      end
      return SINE_W'(v);
   endfunction

   // Whole quarter-wave table, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[SINE_IDX_BITS'(k)] = sine_entry(SINE_IDX_BITS'(k));
      end
      return rom;
   endfunction

endpackage

>>> rtl/core/decaying_sine_generator.sv
// Decaying sine generator: one sample per tick within the run, built on a bit-serial multiplier and divider.
// A tick walks table read, table times amplitude, times envelope, then in float format for a nonzero
//   product the serial divide by 32767 and float packing, then envelope times decay, then the output.
// Ticks are stalled until the sample is handed over; the three shift-add products and the serial
//   divider set the pace. A tick past the run's end leaves the sequencer idle and yields no
//   sample.
// Reset: synchronous, active high; registers and phase/envelope/index return to reset values.
`include "assert_macros.svh"

module decaying_sine_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dsg_pkg::WORD_W-1:0]     rsp_sample_word,
   output logic                           rsp_last_sample,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dsg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dsg_pkg::CFG_W-1:0]      pwdata,
   output logic [dsg_pkg::CFG_W-1:0]      prdata,
   output logic                           pready
);
   import dsg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Configuration registers
   logic [CFG_W-1:0] phase_inc_ff;
   logic [AMP_W-1:0] amplitude_ff;
   logic [CFG_W-1:0] decay_ff;
   logic [CFG_W-1:0] count_ff;
   logic             format_ff;
   logic             csr_write;

   // Sequencer and run state
   dsg_state_type          state_ff, state_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [ENV_W-1:0]       env_ff, env_in;
   logic [CFG_W-1:0]       index_ff, index_in;

   // Per-sample payload
   logic                   neg_ff, neg_in;
   logic                   full_ff, full_in;
   logic                   last_ff, last_in;
   logic [SINE_W-1:0]      rom_q_ff;
   logic [WORD_W-1:0]      word_ff, word_in;

   // Bit-serial multiplier
   logic [MUL_W-1:0]       mul_a_ff, mul_a_in;
   logic [MUL_W-1:0]       mul_b_ff, mul_b_in;
   logic [2*MUL_W-1:0]     prod_ff, prod_in;
   logic [MUL_CNT_W-1:0]   mul_cnt_ff, mul_cnt_in;
   logic [MUL_W:0]         mul_sum;
   logic [2*MUL_W-1:0]     mul_step;
   logic                   mul_last;

   // Bit-serial divider by full scale
   logic [PROD_W-1:0]      samp_ff, samp_in;
   logic [SINE_W-1:0]      conv_rem_ff, conv_rem_in;
   logic [MANT_BITS-1:0]   conv_q_ff, conv_q_in;
   logic [MANT_CNT_W-1:0]  conv_cnt_ff, conv_cnt_in;
   logic signed [POS_W-1:0] conv_pos_ff, conv_pos_in;
   logic signed [POS_W-1:0] conv_exp_ff, conv_exp_in;
   logic [SINE_W:0]        conv_t;
   logic [SINE_W:0]        conv_sub;
   logic                   conv_qbit;
   logic                   conv_take;
   logic [MANT_CNT_W-1:0]  conv_cnt_step;
   logic                   conv_last;

   // Float packing
   logic                   pack_sticky;
   logic                   pack_round;
   logic [MANT_BITS-1:0]   pack_mant;
   logic [FLOAT_EXP_W-1:0] pack_exp;
   logic [WORD_W-1:0]      pack_word;

   // Int16 path
   logic [INT_W-1:0]       int_s;
   logic [SINE_W-1:0]      int_sat;
   logic [WORD_W-1:0]      int_word;
   logic                   prod_nonzero;

   // Tick decode
   logic                     req_accept;
   logic [PHASE_BITS-1:0]    phase_eff;
   logic [CFG_W-1:0]         index_eff;
   logic                     run_go;
   logic [SINE_IDX_BITS-1:0] tab_idx;
   logic                     tab_odd;
   logic [SINE_IDX_BITS-1:0] rom_addr;
   logic [SINE_W-1:0]        mag;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      rsp_word_ff, rsp_word_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_room;
   logic                   out_fire;

   // Handshake and configuration port
   assign req_stall       = (state_ff != S_IDLE);
   assign req_accept      = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_word = rsp_word_ff;
   assign rsp_last_sample = rsp_last_ff;
   assign pready          = 1'b1;
   assign csr_write       = psel && penable && pwrite && pready;

   // Read back the addressed register
   always_comb begin
      case (paddr[CSR_ADDR_W-1 -: REG_IDX_W])
         REG_PHASE_INC: prdata = phase_inc_ff;
         REG_AMPLITUDE: prdata = CFG_W'(amplitude_ff);
         REG_DECAY:     prdata = decay_ff;
         REG_COUNT:     prdata = count_ff;
         REG_FORMAT:    prdata = CFG_W'(format_ff);
         default:       prdata = '0;
      endcase
   end

   // Apply restart ahead of this tick and look up the quadrant's table entry
   assign phase_eff = req_restart ? '0 : phase_ff;
   assign index_eff = req_restart ? '0 : index_ff;
   assign run_go    = index_eff < count_ff;
   assign tab_idx   = phase_eff[PHASE_BITS-3 -: SINE_IDX_BITS];
   assign tab_odd   = phase_eff[PHASE_BITS-2];
   assign rom_addr  = tab_odd ? (SINE_IDX_BITS'(0) - tab_idx) : tab_idx;
   assign mag       = full_ff ? FULL_SCALE : rom_q_ff;

   // Shift-add step: add the multiplicand on a set multiplier bit, shift right
   assign mul_sum  = {1'b0, prod_ff[2*MUL_W-1:MUL_W]}
                   + {1'b0, (mul_b_ff[0] ? mul_a_ff : {MUL_W{1'b0}})};
   assign mul_step = {mul_sum, prod_ff[MUL_W-1:1]};
   assign mul_last = (mul_cnt_ff == MUL_CNT_W'(MUL_W - 1));

   // Restoring divide step: bring down one product bit, subtract full scale if it fits
   assign conv_t        = {conv_rem_ff, samp_ff[PROD_W-1]};
   assign conv_qbit     = (conv_t >= {1'b0, FULL_SCALE});
   assign conv_sub      = conv_t - {1'b0, FULL_SCALE};
   assign conv_take     = (conv_cnt_ff != '0) || conv_qbit;
   assign conv_cnt_step = conv_cnt_ff + MANT_CNT_W'(conv_take);
   assign conv_last     = (conv_cnt_step == MANT_CNT_W'(MANT_BITS));

   // Round to nearest even and assemble the single-precision word
   assign pack_sticky = (conv_rem_ff != '0) || (samp_ff != '0);
   assign pack_round  = conv_q_ff[0] && (pack_sticky || conv_q_ff[1]);
   assign pack_mant   = {1'b0, conv_q_ff[MANT_BITS-1:1]} + MANT_BITS'(pack_round);
   assign pack_exp    = conv_exp_ff[FLOAT_EXP_W-1:0] + FLOAT_EXP_W'(FLOAT_EXP_OFFSET)
                      + FLOAT_EXP_W'(pack_mant[MANT_BITS-1]);
   assign pack_word   = {neg_ff, pack_exp, pack_mant[FLOAT_FRAC_W-1:0]};

   // Truncate, saturate and sign the int16 sample from the finished product
   assign int_s        = mul_step[PROD_W-1:SAMPLE_SHIFT];
   assign int_sat      = (int_s > INT_W'(FULL_SCALE)) ? FULL_SCALE : int_s[SINE_W-1:0];
   assign int_word     = neg_ff ? (WORD_W'(0) - WORD_W'(int_sat)) : WORD_W'(int_sat);
   assign prod_nonzero = (mul_step[PROD_W-1:0] != '0);

   assign out_room = !rsp_valid_ff || !rsp_stall;
   assign out_fire = (state_ff == S_OUT) && out_room;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && run_go) begin
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            if (mul_last) begin
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mul_last) begin
               if (format_ff == FMT_FLOAT32 && prod_nonzero) begin
                  state_in = S_CONV;
               end else begin
                  state_in = S_MUL3;
               end
            end
         end
         S_CONV: begin
            if (conv_last) begin
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (mul_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_room) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      phase_in     = phase_ff;
      env_in       = env_ff;
      index_in     = index_ff;
      neg_in       = neg_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      prod_in      = prod_ff;
      mul_cnt_in   = mul_cnt_ff;
      samp_in      = samp_ff;
      conv_rem_in  = conv_rem_ff;
      conv_q_in    = conv_q_ff;
      conv_cnt_in  = conv_cnt_ff;
      conv_pos_in  = conv_pos_ff;
      conv_exp_in  = conv_exp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      // Take a tick: clear run state on restart, latch quadrant and last flag
      if (req_accept) begin
         phase_in = phase_eff;
         env_in   = req_restart ? ONE_Q31 : env_ff;
         index_in = index_eff;
         neg_in   = phase_eff[PHASE_BITS-1];
         full_in  = tab_odd && (tab_idx == '0);
         last_in  = (index_eff + CFG_W'(1)) == count_ff;
      end

      // Advance the multiplier in any multiply state
      if (state_ff == S_MUL1 || state_ff == S_MUL2 || state_ff == S_MUL3) begin
         prod_in    = mul_step;
         mul_b_in   = mul_b_ff >> 1;
         mul_cnt_in = mul_cnt_ff + MUL_CNT_W'(1);
      end

      // Load operands when a new product starts
      if (state_in != state_ff) begin
         case (state_in)
            S_MUL1: begin
               mul_a_in   = MUL_W'(mag);
               mul_b_in   = MUL_W'(amplitude_ff);
               prod_in    = '0;
               mul_cnt_in = '0;
            end
            S_MUL2: begin
               mul_a_in   = mul_step[MUL_W-1:0];
               mul_b_in   = MUL_W'(env_ff);
               prod_in    = '0;
               mul_cnt_in = '0;
            end
            S_MUL3: begin
               mul_a_in   = MUL_W'(env_ff);
               mul_b_in   = MUL_W'(decay_ff);
               prod_in    = '0;
               mul_cnt_in = '0;
            end
            default: begin
            end
         endcase
      end

      // Finished sample product: keep it, form the int16 word, arm the divider
      if (state_ff == S_MUL2 && mul_last) begin
         samp_in     = mul_step[PROD_W-1:0];
         word_in     = (format_ff == FMT_FLOAT32) ? '0 : int_word;
         conv_rem_in = '0;
         conv_q_in   = '0;
         conv_cnt_in = '0;
         conv_pos_in = POS_W'(PROD_W - 1);
      end

      // One quotient bit per cycle until the mantissa and rounding bit are in
      if (state_ff == S_CONV) begin
         samp_in     = samp_ff << 1;
         conv_rem_in = conv_qbit ? conv_sub[SINE_W-1:0] : conv_t[SINE_W-1:0];
         conv_pos_in = conv_pos_ff - POS_W'(1);
         conv_cnt_in = conv_cnt_step;
         if (conv_take) begin
            conv_q_in = {conv_q_ff[MANT_BITS-2:0], conv_qbit};
         end
         if (conv_cnt_ff == '0 && conv_qbit) begin
            conv_exp_in = conv_pos_ff;
         end
      end

      if (state_ff == S_PACK) begin
         word_in = pack_word;
      end

      // Drop a taken result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Hand the sample over and step phase, envelope and count
      if (out_fire) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = word_ff;
         rsp_last_in  = last_ff;
         phase_in     = phase_ff + PHASE_BITS'(phase_inc_ff);
         env_in       = prod_ff[2*MUL_W-1 -: ENV_W];
         index_in     = index_ff + CFG_W'(1);
      end
   end

   // Control and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= PHASE_INC_RESET;
         amplitude_ff <= AMP_RESET;
         decay_ff     <= DECAY_RESET;
         count_ff     <= COUNT_RESET;
         format_ff    <= FMT_INT16;
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         env_ff       <= ONE_Q31;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (paddr[CSR_ADDR_W-1 -: REG_IDX_W])
               REG_PHASE_INC: phase_inc_ff <= pwdata;
               REG_AMPLITUDE: amplitude_ff <= pwdata[AMP_W-1:0];
               REG_DECAY:     decay_ff     <= pwdata;
               REG_COUNT:     count_ff     <= pwdata;
               REG_FORMAT:    format_ff    <= pwdata[0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         env_ff       <= env_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and table read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rom_q_ff <= SINE_ROM[rom_addr];
      end
      neg_ff      <= neg_in;
      full_ff     <= full_in;
      last_ff     <= last_in;
      word_ff     <= word_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= prod_in;
      mul_cnt_ff  <= mul_cnt_in;
      samp_ff     <= samp_in;
      conv_rem_ff <= conv_rem_in;
      conv_q_ff   <= conv_q_in;
      conv_cnt_ff <= conv_cnt_in;
      conv_pos_ff <= conv_pos_in;
      conv_exp_ff <= conv_exp_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Checks
   `DSG_ASSERT_NXT(a_idle_hold, clock, reset, state_ff == S_IDLE && !req_accept, state_ff == S_IDLE, "sequencer left idle without a tick")
   `DSG_ASSERT_IMP(a_mul1_fits, clock, reset, state_ff == S_MUL1 && mul_last, mul_step[2*MUL_W-1:MUL_W-1] == '0, "table times amplitude overflows 31 bits")
   `DSG_ASSERT_IMP(a_mant_norm, clock, reset, state_ff == S_PACK, conv_q_ff[MANT_BITS-1], "float mantissa not normalized")
   `DSG_ASSERT_NXT(a_env_decays, clock, reset, out_fire, env_ff <= $past(env_ff), "envelope grew after a sample")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the decaying sine generator: directed edge cases, then random runs.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD     = 6;
   localparam int          SETTLE_CYCLES   = 300;
   localparam int          LUT_DEPTH       = dsg_pkg::SINE_TABLE_DEPTH;
   localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
   localparam logic [63:0] PEAK_CODE       = 64'd32767;
   localparam logic [31:0] UNITY_Q31       = 32'h8000_0000;
   localparam int          RANDOM_PHASES   = 8;
   localparam int          TICKS_PER_PHASE = 47;

   typedef struct packed {
      logic [dsg_pkg::WORD_W-1:0] word;
      logic                       last;
   } sample_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SCATTER,
      STALL_LONG
   } stall_mode_type;

   // DUT ports; the inputs are driven to known values from time zero
   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   logic                           req_restart = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   logic [dsg_pkg::WORD_W-1:0]     rsp_sample_word;
   logic                           rsp_last_sample;
   logic                           psel        = 1'b0;
   logic                           penable     = 1'b0;
   logic                           pwrite      = 1'b0;
   logic [dsg_pkg::CSR_ADDR_W-1:0] paddr       = '0;
   logic [dsg_pkg::CFG_W-1:0]      pwdata      = '0;
   logic [dsg_pkg::CFG_W-1:0]      prdata;
   logic                           pready;

   // Predictor copy of the registers and the oscillator state
   logic [31:0] cfg_phase_step;
   logic [15:0] cfg_amplitude;
   logic [31:0] cfg_decay;
   logic [31:0] cfg_run_length;
   logic        cfg_format;
   logic [31:0] phase_acc;
   logic [31:0] envelope_q31;
   logic [31:0] run_index;
   logic [14:0] sine_lut [LUT_DEPTH];

   sample_type  expected_samples[$];

   int          tick_count;
   int          silent_ticks;
   int          restart_count;
   int          csr_writes;
   int          samples_checked;
   int          mismatch_count;

   stall_mode_type stall_mode    = STALL_NONE;
   int          stall_mode_left  = 0;
   int          stall_run        = 0;

   decaying_sine_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_word (rsp_sample_word),
      .rsp_last_sample (rsp_last_sample),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Clock: 12 ns period
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Quarter-wave entry k: Q30 Taylor series of sin up to x^17, rounded to 32767 full scale
   function automatic logic [14:0] quarter_sine(input int k);
      logic [63:0] x;
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] scaled;
      longint      acc;
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(LUT_DEPTH);
      x_sq = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (longint'(1) << 30)) begin
         acc = longint'(1) << 30;
      end
      scaled = (64'(acc) * PEAK_CODE + (64'd1 << 29)) >> 30;
      if (scaled > PEAK_CODE) begin
         scaled = PEAK_CODE;
      end
      return scaled[14:0];
   endfunction

   // IEEE single bits of mag / (32767 * 2^46), round to nearest even
   function automatic logic [31:0] to_single(input logic [63:0] mag);
      logic [63:0] quot;
      logic [63:0] rem;
      logic [31:0] mant;
      logic [7:0]  biased;
      int          exp2;
      bit          sticky;
      if (mag == 0) begin
         return 32'd0;
      end
      quot   = mag / PEAK_CODE;
      rem    = mag % PEAK_CODE;
      exp2   = 0;
      sticky = 1'b0;
      // normalize the quotient to 25 bits: 24 mantissa bits plus a round bit
      while (quot >= (64'd1 << 25)) begin
         sticky = sticky | quot[0];
         quot   = quot >> 1;
         exp2++;
      end
      while (quot < (64'd1 << 24)) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= PEAK_CODE) begin
            rem     = rem - PEAK_CODE;
            quot[0] = 1'b1;
         end
         exp2--;
      end
      if (rem != 0) begin
         sticky = 1'b1;
      end
      mant = quot[32:1];
      if (quot[0] && (sticky || mant[0])) begin
         mant++;
      end
      exp2++;
      if (mant >= (32'd1 << 24)) begin
         mant = mant >> 1;
         exp2++;
      end
      biased = 8'(exp2 - 23 + 127);
      return {1'b0, biased, mant[22:0]};
   endfunction

   // Advance the oscillator by one accepted tick and queue the sample it produces
   task automatic predict_tick(input logic restart_bit);
      logic [1:0]  quadrant;
      logic [9:0]  slot;
      logic [14:0] magnitude;
      logic [63:0] product;
      logic [63:0] whole;
      logic [31:0] word;
      sample_type  sample;
      if (restart_bit) begin
         phase_acc    = '0;
         envelope_q31 = UNITY_Q31;
         run_index    = '0;
         restart_count++;
      end
      if (run_index >= cfg_run_length) begin
         silent_ticks++;
         return;
      end
      quadrant = phase_acc[31:30];
      slot     = phase_acc[29:20];
      if (!quadrant[0]) begin
         magnitude = sine_lut[slot];
      end else if (slot == 0) begin
         magnitude = PEAK_CODE[14:0];
      end else begin
         magnitude = sine_lut[LUT_DEPTH - int'(slot)];
      end
      product = 64'(magnitude) * 64'(cfg_amplitude) * 64'(envelope_q31);
      if (cfg_format == dsg_pkg::FMT_INT16) begin
         whole = product >> 46;
         if (whole > PEAK_CODE) begin
            whole = PEAK_CODE;
         end
         word = quadrant[1] ? (32'd0 - whole[31:0]) : whole[31:0];
      end else begin
         word = to_single(product);
         if (quadrant[1] && word != 0) begin
            word[31] = 1'b1;
         end
      end
      sample.word = word;
      sample.last = (run_index + 32'd1 == cfg_run_length);
      expected_samples.push_back(sample);
      phase_acc    = phase_acc + cfg_phase_step;
      envelope_q31 = 32'((64'(envelope_q31) * 64'(cfg_decay)) >> 32);
      run_index    = run_index + 32'd1;
   endtask

   // Present one tick and hold it until the block takes it
   task automatic send_tick(input logic restart_bit);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_restart <= restart_bit;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_tick(restart_bit);
      tick_count++;
   endtask

   // Drop valid for a number of cycles
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Hold off the sender until every queued sample has been checked
   task automatic wait_for_samples();
      idle_for(1);
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Drain and let any tick that yields nothing finish before touching registers
   task automatic settle_block();
      wait_for_samples();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [dsg_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      case (idx)
         dsg_pkg::REG_PHASE_INC: cfg_phase_step = value;
         dsg_pkg::REG_AMPLITUDE: cfg_amplitude  = value[15:0];
         dsg_pkg::REG_DECAY:     cfg_decay      = value;
         dsg_pkg::REG_COUNT:     cfg_run_length = value;
         dsg_pkg::REG_FORMAT:    cfg_format     = value[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] step, input logic [15:0] amp,
                            input logic [31:0] decay, input logic [31:0] run_len,
                            input logic fmt);
      csr_write(dsg_pkg::REG_PHASE_INC, step);
      csr_write(dsg_pkg::REG_AMPLITUDE, 32'(amp));
      csr_write(dsg_pkg::REG_DECAY, decay);
      csr_write(dsg_pkg::REG_COUNT, run_len);
      csr_write(dsg_pkg::REG_FORMAT, 32'(fmt));
   endtask

   // Reset values: zero phase step gives silence
   task automatic test_reset_values();
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      settle_block();
   endtask

   // Quarter-turn step lands on every quadrant boundary; run ends, later ticks are dropped
   task automatic test_quadrant_edges();
      write_all(32'h4000_0000, 16'h8000, 32'hFFFF_FFFF, 32'd5, dsg_pkg::FMT_INT16);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      settle_block();
   endtask

   // Amplitude above 1.0 clips symmetrically at +/-32767
   task automatic test_saturation();
      csr_write(dsg_pkg::REG_AMPLITUDE, 32'h0000_FFFF);
      csr_write(dsg_pkg::REG_COUNT, 32'd4);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      settle_block();
   endtask

   // Float zeros are +0.0 even on the negative half; then full-scale step with zero decay
   task automatic test_float_edges();
      csr_write(dsg_pkg::REG_FORMAT, 32'(dsg_pkg::FMT_FLOAT32));
      csr_write(dsg_pkg::REG_AMPLITUDE, 32'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      settle_block();
      csr_write(dsg_pkg::REG_AMPLITUDE, 32'h0000_8000);
      csr_write(dsg_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
      csr_write(dsg_pkg::REG_DECAY, 32'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      settle_block();
   endtask

   // A run length of zero never yields a sample, restart or not
   task automatic test_zero_count();
      csr_write(dsg_pkg::REG_COUNT, 32'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      settle_block();
   endtask

   // Register changes mid-run take effect without disturbing the state
   task automatic test_config_mid_run();
      write_all(32'h1234_5678, 16'h7FFF, 32'hFF00_0000, 32'd100, dsg_pkg::FMT_INT16);
      send_tick(1'b1);
      send_tick(1'b0);
      settle_block();
      csr_write(dsg_pkg::REG_PHASE_INC, 32'h0800_0000);
      csr_write(dsg_pkg::REG_AMPLITUDE, 32'h0000_4000);
      csr_write(dsg_pkg::REG_FORMAT, 32'(dsg_pkg::FMT_FLOAT32));
      send_tick(1'b0);
      settle_block();
   endtask

   // Random settings per phase, random ticks in bursts with frequent restarts
   task automatic test_random_runs();
      logic [31:0] step;
      logic [15:0] amp;
      logic [31:0] decay;
      logic [31:0] run_len;
      int          sent;
      int          burst;
      int          gap;
      int          drain_at;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 4))
            0:       step = 32'hFFFF_FFFF;
            1:       step = 32'($urandom_range(1, 32'h00FF_FFFF));
            2:       step = 32'h4000_0000 + 32'($urandom_range(0, 255));
            default: step = $urandom;
         endcase
         case ($urandom_range(0, 5))
            0:       amp = 16'h8000;
            1:       amp = 16'hFFFF;
            2:       amp = 16'h0000;
            default: amp = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       decay = 32'hFFFF_FFFF;
            1:       decay = 32'd0;
            2:       decay = $urandom;
            default: decay = 32'hF000_0000 | $urandom;
         endcase
         case ($urandom_range(0, 6))
            0:       run_len = 32'hFFFF_FFFF;
            1:       run_len = 32'd1;
            default: run_len = 32'($urandom_range(2, 40));
         endcase
         write_all(step, amp, decay, run_len, 1'($urandom_range(0, 1)));
         sent     = 0;
         drain_at = $urandom_range(5, TICKS_PER_PHASE - 5);
         while (sent < TICKS_PER_PHASE) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < TICKS_PER_PHASE; b++) begin
               send_tick($urandom_range(0, 9) == 0);
               sent++;
               if (sent == drain_at) begin
                  wait_for_samples();
               end
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: gap = 0;
               5, 6, 7:       gap = $urandom_range(1, 6);
               8:             gap = $urandom_range(20, 120);
               default:       gap = $urandom_range(7, 19);
            endcase
            idle_for(gap);
         end
         settle_block();
      end
   endtask

   // Receiver stall pattern: quiet stretches, scattered stalls and long holds
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 2));
         stall_mode_left <= $urandom_range(200, 1500);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else begin
         case (stall_mode)
            STALL_SCATTER: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_LONG: begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 15) == 0) begin
                  stall_run <= $urandom_range(5, 60);
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Compare every accepted sample transaction against the oldest expectation
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample word=%h last=%b", $time,
                     rsp_sample_word, rsp_last_sample);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample_word !== want.word) begin
               $display("%0t: sample_word expected %h actual %h", $time,
                        want.word, rsp_sample_word);
               mismatch_count++;
            end
            if (rsp_last_sample !== want.last) begin
               $display("%0t: last_sample expected %b actual %b", $time,
                        want.last, rsp_last_sample);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("decaying_sine_generator: mismatch");
      $finish;
   end

   initial begin
      // predictor at reset
      cfg_phase_step  = 32'd0;
      cfg_amplitude   = 16'h8000;
      cfg_decay       = 32'hFFFF_FFFF;
      cfg_run_length  = 32'd48000;
      cfg_format      = dsg_pkg::FMT_INT16;
      phase_acc       = '0;
      envelope_q31    = UNITY_Q31;
      run_index       = '0;
      tick_count      = 0;
      silent_ticks    = 0;
      restart_count   = 0;
      csr_writes      = 0;
      samples_checked = 0;
      mismatch_count  = 0;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         sine_lut[k] = quarter_sine(k);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_quadrant_edges();
      test_saturation();
      test_float_edges();
      test_zero_count();
      test_config_mid_run();
      test_random_runs();

      settle_block();
      $display("ran %0d ticks (%0d restarts, %0d past run end), %0d register writes",
               tick_count, restart_count, silent_ticks, csr_writes);
      $display("checked %0d samples in int16 and float formats, %0d mismatches",
               samples_checked, mismatch_count);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("decaying_sine_generator: match");
      end else begin
         $display("decaying_sine_generator: mismatch");
      end
      $finish;
   end

endmodule
